FILE: hdl/gle_pkg.sv
package gle_pkg;

    localparam int PIX_W   = 8;
    localparam int CODE_W  = 12;
    localparam int FREE_W  = 13;
    localparam int WID_W   = 4;
    localparam int HASH_W  = 13;
    localparam int EPOCH_W = 6;
    localparam int WORD_W  = EPOCH_W + CODE_W + PIX_W + CODE_W;
    localparam int BUF_W   = 20;
    localparam int FILL_W  = 5;

    localparam logic [CODE_W-1:0] CODE_CLEAR  = 12'd256;
    localparam logic [CODE_W-1:0] CODE_EOI    = 12'd257;
    localparam logic [FREE_W-1:0] CODE_FIRST  = 13'd258;
    localparam logic [FREE_W-1:0] CODE_LIMIT  = 13'd4096;
    localparam logic [WID_W-1:0]  START_WIDTH = 4'd9;
    localparam logic [WID_W-1:0]  MAX_WIDTH   = 4'd12;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_end;
    } item_t;

    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] code;
        logic [WID_W-1:0]  width;
        logic              flush;
    } code_req_t;

    typedef struct packed {
        logic              sweeping;
        logic [FREE_W-1:0] free_code;
    } dict_status_t;

endpackage

FILE: hdl/gle_ifs.sv
interface gle_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;
    logic       frame_end;
    modport source (output valid, output pixel, output frame_end, input ready);
    modport sink (input valid, input pixel, input frame_end, output ready);
endinterface

interface gle_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] packed_byte;
    logic       stream_last;
    modport source (output valid, output packed_byte, output stream_last, input ready);
    modport sink (input valid, input packed_byte, input stream_last, output ready);
endinterface

FILE: hdl/gle_front.sv
module gle_front
    import gle_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    gle_pix_if.sink pix,
    input  logic   hold,
    output item_t  q_item,
    output logic   q_valid,
    input  logic   q_pop
);

    // Two-entry queue between the pixel port and the dictionary engine.
    item_t      slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;

    assign pix.ready = (count_reg != 2'd2) && !hold;
    assign push      = pix.valid && pix.ready;
    assign q_valid   = (count_reg != 2'd0);
    assign q_item    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + 1'b1;
        rd_ptr_next = rd_ptr_reg + 1'b1;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
        if (!push)
        begin
            wr_ptr_next = wr_ptr_reg;
        end
        if (!q_pop)
        begin
            rd_ptr_next = rd_ptr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= '{pixel: pix.pixel, frame_end: pix.frame_end};
        end
    end

endmodule

FILE: hdl/gle_dict.sv
module gle_dict
    import gle_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  item_t        q_item,
    input  logic         q_valid,
    output logic         q_pop,
    output code_req_t    req,
    input  logic         req_ready,
    output dict_status_t status
);

    typedef enum logic [8:0] {
        S_SWEEP = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_START = 9'b000000100,
        S_READ  = 9'b000001000,
        S_CMP   = 9'b000010000,
        S_PFX   = 9'b000100000,
        S_CLR   = 9'b001000000,
        S_FIN   = 9'b010000000,
        S_EOI   = 9'b100000000
    } state_t;

    state_t              state_reg, state_next;
    logic [HASH_W-1:0]   sweep_reg, sweep_next;
    logic [HASH_W-1:0]   probe_reg, probe_next;
    logic [EPOCH_W-1:0]  epoch_reg, epoch_next;
    logic [FREE_W-1:0]   free_reg, free_next;
    logic [WID_W-1:0]    width_reg, width_next;
    logic [CODE_W-1:0]   prefix_reg, prefix_next;
    logic [PIX_W-1:0]    pix_reg, pix_next;
    logic                last_reg, last_next;
    logic                in_frame_reg, in_frame_next;
    logic [CODE_W+PIX_W-1:0] key_reg, key_next;

    // Hash table: each word is {epoch tag, key, code}. A slot is live only
    // when its tag equals the current epoch, so a dictionary clear is a tag bump.
    logic [WORD_W-1:0]   mem [2**HASH_W];
    logic [WORD_W-1:0]   rd_reg;
    logic                we, re;
    logic [HASH_W-1:0]   waddr;
    logic [WORD_W-1:0]   wdata;

    logic [EPOCH_W-1:0]  rd_tag;
    logic [CODE_W+PIX_W-1:0] rd_key;
    logic [CODE_W-1:0]   rd_code;
    logic [FREE_W-1:0]   free_inc;
    logic [FREE_W-1:0]   width_span;
    logic [HASH_W-1:0]   hash;
    logic [CODE_W+PIX_W-1:0] new_key;

    assign {rd_tag, rd_key, rd_code} = rd_reg;
    assign free_inc   = free_reg + 1'b1;
    assign width_span = FREE_W'(1) << width_reg;
    assign new_key    = {prefix_reg, q_item.pixel};
    assign hash       = {prefix_reg[4:0], q_item.pixel} ^ {prefix_reg[11:5], 6'b0};

    assign status.sweeping  = (state_reg == S_SWEEP);
    assign status.free_code = free_reg;

    always_comb
    begin
        state_next    = state_reg;
        sweep_next    = sweep_reg;
        probe_next    = probe_reg;
        epoch_next    = epoch_reg;
        free_next     = free_reg;
        width_next    = width_reg;
        prefix_next   = prefix_reg;
        pix_next      = pix_reg;
        last_next     = last_reg;
        in_frame_next = in_frame_reg;
        key_next      = key_reg;
        q_pop         = 1'b0;
        we            = 1'b0;
        re            = 1'b0;
        waddr         = probe_reg;
        wdata         = {epoch_reg, key_reg, free_reg[CODE_W-1:0]};
        req           = '{valid: 1'b0, code: prefix_reg, width: width_reg, flush: 1'b0};

        unique case (state_reg)
            S_SWEEP:
            begin
                we         = 1'b1;
                waddr      = sweep_reg;
                wdata      = '0;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == {HASH_W{1'b1}})
                begin
                    epoch_next = EPOCH_W'(1);
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (epoch_reg == '0)
                begin
                    state_next = S_SWEEP;
                end
                else if (q_valid)
                begin
                    q_pop     = 1'b1;
                    pix_next  = q_item.pixel;
                    last_next = q_item.frame_end;
                    if (!in_frame_reg)
                    begin
                        epoch_next = epoch_reg + 1'b1;
                        free_next  = CODE_FIRST;
                        width_next = START_WIDTH;
                        state_next = S_START;
                    end
                    else
                    begin
                        key_next   = new_key;
                        probe_next = hash;
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                re         = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (rd_tag == epoch_reg && rd_key == key_reg)
                begin
                    prefix_next = rd_code;
                    state_next  = last_reg ? S_FIN : S_IDLE;
                end
                else if (rd_tag == epoch_reg)
                begin
                    probe_next = probe_reg + 1'b1;
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_PFX;
                end
            end
            S_PFX:
            begin
                req.valid = 1'b1;
                if (req_ready)
                begin
                    prefix_next = {{(CODE_W-PIX_W){1'b0}}, pix_reg};
                    if (free_reg[FREE_W-1])
                    begin
                        state_next = S_CLR;
                    end
                    else
                    begin
                        we        = 1'b1;
                        free_next = free_inc;
                        if (free_inc > width_span && width_reg < MAX_WIDTH)
                        begin
                            width_next = width_reg + 1'b1;
                        end
                        state_next = last_reg ? S_FIN : S_IDLE;
                    end
                end
            end
            S_CLR:
            begin
                req.valid = 1'b1;
                req.code  = CODE_CLEAR;
                if (req_ready)
                begin
                    epoch_next = epoch_reg + 1'b1;
                    free_next  = CODE_FIRST;
                    width_next = START_WIDTH;
                    state_next = last_reg ? S_FIN : S_IDLE;
                end
            end
            S_START:
            begin
                req.valid = 1'b1;
                req.code  = CODE_CLEAR;
                if (req_ready)
                begin
                    prefix_next   = {{(CODE_W-PIX_W){1'b0}}, pix_reg};
                    in_frame_next = 1'b1;
                    state_next    = last_reg ? S_FIN : S_IDLE;
                end
            end
            S_FIN:
            begin
                req.valid = 1'b1;
                if (req_ready)
                begin
                    state_next = S_EOI;
                end
            end
            S_EOI:
            begin
                req.valid = 1'b1;
                req.code  = CODE_EOI;
                req.flush = 1'b1;
                if (req_ready)
                begin
                    in_frame_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_SWEEP;
            sweep_reg    <= '0;
            epoch_reg    <= '0;
            free_reg     <= CODE_FIRST;
            width_reg    <= START_WIDTH;
            prefix_reg   <= '0;
            in_frame_reg <= 1'b0;
            last_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            sweep_reg    <= sweep_next;
            epoch_reg    <= epoch_next;
            free_reg     <= free_next;
            width_reg    <= width_next;
            prefix_reg   <= prefix_next;
            in_frame_reg <= in_frame_next;
            last_reg     <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        probe_reg <= probe_next;
        pix_reg   <= pix_next;
        key_reg   <= key_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_reg <= mem[probe_reg];
        end
    end

endmodule

FILE: hdl/gle_pack.sv
module gle_pack
    import gle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  code_req_t   req,
    output logic        req_ready,
    gle_byte_if.source  bytes,
    output logic [FILL_W-1:0] fill
);

    logic [BUF_W-1:0]  buf_reg, buf_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              flush_reg, flush_next;
    logic              ob_valid_reg, ob_valid_next;
    logic [7:0]        ob_byte_reg, ob_byte_next;
    logic              ob_last_reg, ob_last_next;
    logic              ob_free;
    logic [BUF_W-1:0]  masked;

    assign req_ready         = (fill_reg < FILL_W'(8)) && !flush_reg;
    assign ob_free           = !ob_valid_reg || bytes.ready;
    assign bytes.valid       = ob_valid_reg;
    assign bytes.packed_byte = ob_byte_reg;
    assign bytes.stream_last = ob_last_reg;
    assign fill              = fill_reg;
    assign masked = BUF_W'(req.code & CODE_W'((13'd1 << req.width) - 13'd1));

    always_comb
    begin
        buf_next      = buf_reg;
        fill_next     = fill_reg;
        flush_next    = flush_reg;
        ob_valid_next = ob_valid_reg && !bytes.ready;
        ob_byte_next  = ob_byte_reg;
        ob_last_next  = ob_last_reg;

        if (req.valid && req_ready)
        begin
            buf_next   = buf_reg | (masked << fill_reg);
            fill_next  = fill_reg + FILL_W'(req.width);
            flush_next = req.flush;
        end
        else if (ob_free)
        begin
            priority if (fill_reg >= FILL_W'(8))
            begin
                ob_valid_next = 1'b1;
                ob_byte_next  = buf_reg[7:0];
                ob_last_next  = flush_reg && (fill_reg == FILL_W'(8));
                buf_next      = buf_reg >> 8;
                fill_next     = fill_reg - FILL_W'(8);
                if (fill_reg == FILL_W'(8))
                begin
                    flush_next = 1'b0;
                end
            end
            else if (flush_reg && fill_reg != '0)
            begin
                ob_valid_next = 1'b1;
                ob_byte_next  = buf_reg[7:0];
                ob_last_next  = 1'b1;
                buf_next      = '0;
                fill_next     = '0;
                flush_next    = 1'b0;
            end
            else
            begin
                flush_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg      <= '0;
            fill_reg     <= '0;
            flush_reg    <= 1'b0;
            ob_valid_reg <= 1'b0;
        end
        else
        begin
            buf_reg      <= buf_next;
            fill_reg     <= fill_next;
            flush_reg    <= flush_next;
            ob_valid_reg <= ob_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ob_byte_reg <= ob_byte_next;
        ob_last_reg <= ob_last_next;
    end

endmodule

FILE: hdl/gif_lzw_encoder_unit.sv
// GIF LZW encoder for 8-bit palette indices, codes up to 12 bits wide.
// The pix channel takes one pixel per beat with frame_end marking the last
// pixel of a frame; the bytes channel gives the LSB-first packed code stream,
// with stream_last set on the final byte of each frame.
// Pixels enter a two-entry queue, so the port keeps taking beats while the
// dictionary engine works. The engine hashes (prefix, pixel) into an 8192-slot
// table; each probe is an address step followed by a registered read, and a
// pixel needs one more probe per occupied slot whose key does not match, plus
// a code request when the search ends on a free slot. The dictionary read port
// sets the throughput. Each code goes to a bit packer that releases one byte
// per cycle through an output register while the receiver keeps ready high.
// After reset the engine sweeps every slot of the table and the pix port
// holds ready low meanwhile. The same sweep repeats after every 63 dictionary
// clears, when the slot tags wrap. If the receiver stalls, the output register
// holds its byte, the packer fills and stops taking codes, the engine waits,
// and the queue fills and drops ready; nothing is lost.
module gif_lzw_encoder_unit
    import gle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    gle_pix_if.sink    pix,
    gle_byte_if.source bytes
);

    item_t        q_item;
    logic         q_valid;
    logic         q_pop;
    code_req_t    req;
    logic         req_ready;
    dict_status_t status;
    logic [FILL_W-1:0] fill;

    gle_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix     (pix),
        .hold    (status.sweeping),
        .q_item  (q_item),
        .q_valid (q_valid),
        .q_pop   (q_pop)
    );

    gle_dict u_dict (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_item    (q_item),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .req       (req),
        .req_ready (req_ready),
        .status    (status)
    );

    gle_pack u_pack (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .req_ready (req_ready),
        .bytes     (bytes),
        .fill      (fill)
    );

`ifndef NO_ASSERTIONS
    // No pixel is taken while the table sweep runs.
    a_no_take_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        status.sweeping |-> !pix.ready)
        else $error("pixel accepted during table sweep");

    // The next free code never passes one beyond the last 12-bit code.
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        status.free_code <= CODE_LIMIT)
        else $error("free code out of range");

    // Packer never holds more than a partial byte plus one code.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill < FILL_W'(20))
        else $error("bit packer overflow");

    // Codes are always sent at a legal width.
    a_code_width: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid |-> (req.width >= START_WIDTH && req.width <= MAX_WIDTH))
        else $error("code width out of range");
`endif

endmodule
